[src/grbd_pkg.sv]
// ----------------------------------------------------------------------------
// grbd_pkg
// Types, constants and helpers shared by the Rice block decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package grbd_pkg;

   localparam int unsigned HEADER_BITS   = 4;
   localparam int unsigned TOP_BIT       = 7;
   localparam int unsigned MAX_RESULTS   = 4;
   localparam logic [15:0] BLOCK_LEN_RST = 16'd64;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_SIGN   = 4'b0010,
      PH_UNARY  = 4'b0100,
      PH_REM    = 4'b1000
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  field_bit_count;
      logic [14:0] bit_accumulator;
      logic [3:0]  current_k;
      logic        sign_flag;
      logic [31:0] quotient_count;
      logic [15:0] values_left;
   } dec_state_type;

   // one decoded value, kept in raw form until it is sent
   typedef struct packed {
      logic [31:0] quotient;
      logic [14:0] remainder;
      logic        sign;
      logic [3:0]  rice_k;
      logic        block_end;
      logic        run_last;
   } result_type;

   function automatic logic [31:0] rice_value(input result_type r);
      logic [31:0] mag;
      mag = (r.quotient << r.rice_k) + {17'd0, r.remainder};
      return r.sign ? (32'd0 - mag) : mag;
   endfunction

endpackage

`default_nettype wire

[src/grbd_if.sv]
// ----------------------------------------------------------------------------
// grbd channel interfaces
// Valid/ready channels for stream bytes, decoded values and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface grbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface grbd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] decoded_value;
   logic [3:0]        rice_k;
   logic              block_end;
   logic              run_last;
   modport source (output valid, output decoded_value, output rice_k,
                   output block_end, output run_last, input ready);
   modport sink   (input valid, input decoded_value, input rice_k,
                   input block_end, input run_last, output ready);
endinterface

interface grbd_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] write_data;
   modport source (output valid, output write_data, input ready);
   modport sink   (input valid, input write_data, output ready);
endinterface

`default_nettype wire

[src/grbd_step.sv]
// ----------------------------------------------------------------------------
// grbd_step
// Walks the eight bits of one stream byte through the decoder state and
// collects up to four finished values.
// ----------------------------------------------------------------------------
`default_nettype none

module grbd_step (
   input  grbd_pkg::dec_state_type st_cur,
   input  logic [7:0]              stream_byte,
   input  logic [15:0]             block_length,
   output grbd_pkg::dec_state_type st_next,
   output grbd_pkg::result_type    results [grbd_pkg::MAX_RESULTS],
   output logic [2:0]              result_count
);

   always_comb begin
      grbd_pkg::dec_state_type s;
      grbd_pkg::result_type    r [grbd_pkg::MAX_RESULTS];
      logic [2:0]              cnt;
      logic                    b;
      logic                    emit;
      s   = st_cur;
      cnt = 3'd0;
      for (int j = 0; j < grbd_pkg::MAX_RESULTS; j++) begin
         r[j] = '0;
      end
      for (int i = 0; i <= grbd_pkg::TOP_BIT; i++) begin
         b    = stream_byte[3'(grbd_pkg::TOP_BIT - i)];
         emit = 1'b0;
         unique case (s.phase)
            grbd_pkg::PH_HEADER: begin
               s.bit_accumulator = {s.bit_accumulator[13:0], b};
               s.field_bit_count = s.field_bit_count + 4'd1;
               if (s.field_bit_count == 4'(grbd_pkg::HEADER_BITS)) begin
                  s.current_k       = s.bit_accumulator[3:0];
                  s.values_left     = block_length;
                  s.field_bit_count = 4'd0;
                  s.bit_accumulator = 15'd0;
                  // an empty block goes straight back to the header
                  s.phase = (block_length == 16'd0) ? grbd_pkg::PH_HEADER
                                                    : grbd_pkg::PH_SIGN;
               end
            end
            grbd_pkg::PH_SIGN: begin
               s.sign_flag      = b;
               s.quotient_count = 32'd0;
               s.phase          = grbd_pkg::PH_UNARY;
            end
            grbd_pkg::PH_UNARY: begin
               if (b) begin
                  s.quotient_count = s.quotient_count + 32'd1;
               end else if (s.current_k == 4'd0) begin
                  s.bit_accumulator = 15'd0;
                  emit              = 1'b1;
               end else begin
                  s.field_bit_count = 4'd0;
                  s.bit_accumulator = 15'd0;
                  s.phase           = grbd_pkg::PH_REM;
               end
            end
            grbd_pkg::PH_REM: begin
               s.bit_accumulator = {s.bit_accumulator[13:0], b};
               s.field_bit_count = s.field_bit_count + 4'd1;
               emit              = (s.field_bit_count >= s.current_k);
            end
            default: begin
               s.phase = grbd_pkg::PH_HEADER;
            end
         endcase
         if (emit) begin
            r[cnt[1:0]].quotient  = s.quotient_count;
            r[cnt[1:0]].remainder = s.bit_accumulator;
            r[cnt[1:0]].sign      = s.sign_flag;
            r[cnt[1:0]].rice_k    = s.current_k;
            r[cnt[1:0]].block_end = (s.values_left == 16'd1);
            r[cnt[1:0]].run_last  = 1'b0;
            s.values_left         = s.values_left - 16'd1;
            cnt                   = cnt + 3'd1;
            s.phase = (s.values_left == 16'd0) ? grbd_pkg::PH_HEADER
                                               : grbd_pkg::PH_SIGN;
            s.field_bit_count     = 4'd0;
            s.bit_accumulator     = 15'd0;
         end
      end
      for (int j = 0; j < grbd_pkg::MAX_RESULTS; j++) begin
         r[j].run_last = (cnt != 3'd0) && (3'(j) == cnt - 3'd1);
      end
      st_next      = s;
      results      = r;
      result_count = cnt;
   end

endmodule

`default_nettype wire

[src/golomb_rice_block_decoder_top.sv]
// ----------------------------------------------------------------------------
// golomb_rice_block_decoder_top
// Rice code block decoder: one stream byte in, up to four signed values out.
// ----------------------------------------------------------------------------
// Stream bytes enter an input register; once the result queue is free, the
// eight bits of the byte are decoded in one pass and the values they
// complete (zero to four) are loaded into a four-entry result queue, from
// which one value leaves per cycle on rsp_bus while rsp_bus.ready is high.
// A byte that completes at most one value does not stall the input, so
// bytes stream at one per cycle under that condition; a byte that completes
// more values holds the input side while the queue drains. The block_length
// register is always ready for writes and is picked up at the next header.
`default_nettype none

module golomb_rice_block_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   grbd_req_if.sink         req_bus,
   grbd_rsp_if.source       rsp_bus,
   grbd_csr_if.sink         csr_bus
);

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_byte_ff, in_byte_in;
   grbd_pkg::dec_state_type st_ff, st_in, st_step;
   logic [15:0]             blen_ff, blen_in;
   grbd_pkg::result_type    buf_ff [grbd_pkg::MAX_RESULTS];
   grbd_pkg::result_type    buf_in [grbd_pkg::MAX_RESULTS];
   grbd_pkg::result_type    step_res [grbd_pkg::MAX_RESULTS];
   logic [2:0]              cnt_ff, cnt_in, step_cnt;
   logic                    req_take, pop, buf_free, fire;

   grbd_step u_step (
      .st_cur       (st_ff),
      .stream_byte  (in_byte_ff),
      .block_length (blen_ff),
      .st_next      (st_step),
      .results      (step_res),
      .result_count (step_cnt)
   );

   assign rsp_bus.valid         = (cnt_ff != 3'd0);
   assign rsp_bus.decoded_value = signed'(grbd_pkg::rice_value(buf_ff[0]));
   assign rsp_bus.rice_k        = buf_ff[0].rice_k;
   assign rsp_bus.block_end     = buf_ff[0].block_end;
   assign rsp_bus.run_last      = buf_ff[0].run_last;

   assign pop      = rsp_bus.valid && rsp_bus.ready;
   assign buf_free = (cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && pop);
   assign fire     = in_valid_ff && buf_free;
   assign req_bus.ready = !in_valid_ff || fire;
   assign req_take = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      st_in       = st_ff;
      blen_in     = blen_ff;
      cnt_in      = cnt_ff;
      buf_in      = buf_ff;
      if (csr_bus.valid) begin
         blen_in = csr_bus.write_data;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.stream_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      if (fire) begin
         st_in  = st_step;
         cnt_in = step_cnt;
         buf_in = step_res;
      end else if (pop) begin
         // queue shifts towards the head
         for (int j = 0; j < grbd_pkg::MAX_RESULTS - 1; j++) begin
            buf_in[j] = buf_ff[j + 1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         st_ff       <= '{phase: grbd_pkg::PH_HEADER, default: '0};
         blen_ff     <= grbd_pkg::BLOCK_LEN_RST;
         cnt_ff      <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         st_ff       <= st_in;
         blen_ff     <= blen_in;
         cnt_ff      <= cnt_in;
      end
      in_byte_ff <= in_byte_in;
      buf_ff     <= buf_in;
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(grbd_pkg::MAX_RESULTS))
      else $error("result queue count out of range");

   a_last_at_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.run_last) |-> (cnt_ff == 3'd1))
      else $error("last item of a byte is not at the queue tail");

   a_empty_byte: assert property (@(posedge clock) disable iff (reset)
      (fire && (step_cnt == 3'd0)) |=> !rsp_bus.valid)
      else $error("byte with no values left items in the queue");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      fire |=> (cnt_ff == $past(step_cnt)))
      else $error("queue load lost or merged items");
`endif

endmodule

`default_nettype wire
